// ===== rtl/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types and constants for the call stack cycle profiler.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int FUNC_W          = 8;
  localparam int FUNC_COUNT      = 1 << FUNC_W;
  localparam int CNT_W           = FUNC_W + 1;
  localparam int STAMP_W         = 64;
  localparam int DEPTH_W         = 16;
  localparam int STACK_DEPTH_DEF = 128;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_ENTER = 2'd0,
    REQ_EXIT  = 2'd1,
    REQ_DUMP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_EMPTY_EXIT = 2'd1,
    ST_DEPTH_SAT  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,
    S_UPD
  } state_t;

endpackage

// ===== rtl/ccp_ram.sv =====
// ----------------------------------------------------------------------------
// ccp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ccp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/call_stack_cycle_profiler.sv =====
// ----------------------------------------------------------------------------
// call_stack_cycle_profiler
// Mirrors a call stack from enter/exit beats and charges elapsed cycles to
// the function on top; dump beats read and clear totals by registration order.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------
//   in_     | in  | in_valid/in_stall   | req_type, function_id, timestamp,
//           |     |                    | dump_position
//   out_    | out | out_valid/out_stall| status, dump_valid, dump_function,
//           |     |                    | dump_cycles, registered_total
//
// Each beat passes the stack/order RAM read, then the cycle total RAM
// read-modify-write. A result waits in the output register; the next
// beat is taken alongside the write-back unless that register is still
// stalled. Reset is synchronous; seen flags live in flops and clear at
// once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module call_stack_cycle_profiler #(
  parameter int STACK_DEPTH = ccp_pkg::STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_req_type,
  input  logic [ccp_pkg::FUNC_W-1:0]   in_function_id,
  input  logic [ccp_pkg::STAMP_W-1:0]  in_timestamp,
  input  logic [ccp_pkg::FUNC_W-1:0]   in_dump_position,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic                         out_dump_valid,
  output logic [ccp_pkg::FUNC_W-1:0]   out_dump_function,
  output logic [ccp_pkg::STAMP_W-1:0]  out_dump_cycles,
  output logic [ccp_pkg::CNT_W-1:0]    out_registered_total
);

  import ccp_pkg::*;

  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [DEPTH_W-1:0] SD = DEPTH_W'(STACK_DEPTH);

  state_t state_r, state_nxt;

  // beat capture
  req_t               req_r;
  logic [FUNC_W-1:0]  fn_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [FUNC_W-1:0]  pos_r;

  // architectural state
  logic [FUNC_COUNT-1:0] seen_r;
  logic [CNT_W-1:0]      count_r;
  logic [DEPTH_W-1:0]    depth_r, depth_nxt;
  logic [STAMP_W-1:0]    last_r;

  // top stage results
  logic [FUNC_W-1:0]  tgt_r;
  logic               chg_r;
  logic               dv_r;
  logic [STAMP_W-1:0] delta_r;

  // output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic               out_dv_r;
  logic [FUNC_W-1:0]  out_fn_r;
  logic [STAMP_W-1:0] out_cyc_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic out_free, accept, commit;
  logic depth_nz;
  logic new_fn;
  logic [FUNC_W-1:0] tgt;
  logic [DEPTH_W-1:0] slot_full;

  // RAM ports
  logic              stk_we, stk_re;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [FUNC_W-1:0] stk_rdata;
  logic              ord_we;
  logic [FUNC_W-1:0] ord_rdata;
  logic              tot_we, tot_re;
  logic [FUNC_W-1:0] tot_waddr;
  logic [STAMP_W-1:0] tot_wdata, tot_rdata;
  logic [STAMP_W:0]   sum;
  logic [STAMP_W-1:0] sat;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_UPD) && out_free));
  assign accept   = in_valid && !in_stall;
  assign commit   = (state_r == S_UPD) && out_free;
  assign depth_nz = (depth_r != '0);

  // next state, depth update
  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_TOP;
      end
      S_TOP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          state_nxt = in_valid ? S_TOP : S_IDLE;
          if (req_r == REQ_ENTER && depth_r != DEPTH_MAX) begin
            depth_nxt = depth_r + DEPTH_W'(1);
          end else if (req_r == REQ_EXIT && depth_nz) begin
            depth_nxt = depth_r - DEPTH_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      depth_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= req_t'(in_req_type);
      fn_r    <= in_function_id;
      stamp_r <= in_timestamp;
      pos_r   <= in_dump_position;
    end
  end

  // stack top read, issued with the beat; uses the depth after write-back
  assign slot_full = (depth_nxt <= SD) ? (depth_nxt - DEPTH_W'(1)) : (SD - DEPTH_W'(1));
  assign stk_re    = accept;
  assign stk_raddr = slot_full[SAW-1:0];
  assign stk_we    = (state_r == S_TOP) && (req_r == REQ_ENTER) && (depth_r < SD);
  assign stk_waddr = depth_r[SAW-1:0];

  ccp_ram #(.WIDTH(FUNC_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (fn_r),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // registration
  assign new_fn = (state_r == S_TOP) && (req_r == REQ_ENTER) && !seen_r[fn_r];
  assign ord_we = new_fn;

  ccp_ram #(.WIDTH(FUNC_W), .DEPTH(FUNC_COUNT)) u_order (
    .clk   (clk),
    .we    (ord_we),
    .waddr (count_r[FUNC_W-1:0]),
    .wdata (fn_r),
    .re    (accept),
    .raddr (in_dump_position),
    .rdata (ord_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      count_r <= '0;
    end else if (new_fn) begin
      seen_r[fn_r] <= 1'b1;
      count_r      <= count_r + CNT_W'(1);
    end
  end

  // top stage: pick the total to touch
  assign tgt    = (req_r == REQ_DUMP) ? ord_rdata : stk_rdata;
  assign tot_re = (state_r == S_TOP);

  always_ff @(posedge clk) begin
    if (state_r == S_TOP) begin
      tgt_r   <= tgt;
      chg_r   <= (req_r == REQ_ENTER || req_r == REQ_EXIT) && depth_nz;
      dv_r    <= (req_r == REQ_DUMP) && ({1'b0, pos_r} < count_r);
      delta_r <= stamp_r - last_r;
    end
  end

  // saturating charge
  assign sum = {1'b0, tot_rdata} + {1'b0, delta_r};
  assign sat = sum[STAMP_W] ? {STAMP_W{1'b1}} : sum[STAMP_W-1:0];

  always_comb begin
    tot_we    = 1'b0;
    tot_waddr = tgt_r;
    tot_wdata = '0;
    priority if (new_fn) begin
      tot_we    = 1'b1;
      tot_waddr = fn_r;
    end else if (commit && chg_r) begin
      tot_we    = 1'b1;
      tot_wdata = sat;
    end else if (commit && dv_r) begin
      tot_we    = 1'b1;
    end else begin
      tot_we    = 1'b0;
    end
  end

  ccp_ram #(.WIDTH(STAMP_W), .DEPTH(FUNC_COUNT)) u_totals (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .re    (tot_re),
    .raddr (tgt),
    .rdata (tot_rdata)
  );

  // last stamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (commit && (req_r == REQ_ENTER || (req_r == REQ_EXIT && depth_nz))) begin
      last_r <= stamp_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_dv_r  <= dv_r;
      out_fn_r  <= dv_r ? tgt_r : '0;
      out_cyc_r <= dv_r ? tot_rdata : '0;
      out_cnt_r <= count_r;
      if (req_r == REQ_ENTER && depth_r == DEPTH_MAX) begin
        out_status_r <= ST_DEPTH_SAT;
      end else if (req_r == REQ_EXIT && !depth_nz) begin
        out_status_r <= ST_EMPTY_EXIT;
      end else begin
        out_status_r <= ST_DONE;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_dump_valid       = out_dv_r;
  assign out_dump_function    = out_fn_r;
  assign out_dump_cycles      = out_cyc_r;
  assign out_registered_total = out_cnt_r;

  // checks
  a_accept_to_top: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_TOP)
    else $error("accepted beat did not enter top stage");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FUNC_COUNT))
    else $error("registration count beyond function count");

  a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_UPD) |=> depth_r == $past(depth_r))
    else $error("depth changed outside write-back");

  a_out_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && state_r != S_UPD) |=> !out_valid_r)
    else $error("result raised without write-back");

endmodule
